// ===== sv/prs_pkg.sv =====
package prs_pkg;

    localparam int TAG_W   = 16;
    localparam int LEN_W   = 16;
    localparam int KIND_W  = 3;
    localparam int CFG_W   = 24;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] REG_RATE_ENABLED     = 2'd0;
    localparam logic [IDX_W-1:0] REG_TICK_BYTE_BUDGET = 2'd1;
    localparam logic [IDX_W-1:0] REG_BUCKET_THRESHOLD = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_QUEUED   = 3'd0,
        KIND_REJECTED = 3'd1,
        KIND_DIRECT   = 3'd2,
        KIND_RELEASED = 3'd3,
        KIND_FREED    = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUBMIT,
        ST_TCHECK,
        ST_TEMIT
    } t_state;

    typedef struct packed {
        logic ld;
        logic sub;
        logic pop;
        logic free;
    } t_cmd;

    typedef struct packed {
        logic can_pop;
        logic bucket_free;
    } t_sts;

endpackage

// ===== sv/prs_dpath.sv =====
module prs_dpath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  prs_pkg::t_cmd                 i_cmd,
    output prs_pkg::t_sts                 o_sts,
    input  logic                          i_rate_enabled,
    input  logic [prs_pkg::CFG_W-1:0]     i_budget,
    input  logic [prs_pkg::CFG_W-1:0]     i_threshold,
    input  logic [prs_pkg::TAG_W-1:0]     i_tag,
    input  logic [prs_pkg::LEN_W-1:0]     i_len,
    output logic                          o_strobe,
    output logic [prs_pkg::KIND_W-1:0]    o_kind,
    output logic [prs_pkg::TAG_W-1:0]     o_tag,
    output logic [prs_pkg::LEN_W-1:0]     o_len,
    output logic                          o_last
);
    import prs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int TOT_W = $clog2(QUEUE_DEPTH) + LEN_W;
    localparam int CMP_W = (TOT_W > CFG_W) ? TOT_W : CFG_W;
    localparam int ENT_W = TAG_W + LEN_W;

    logic [ENT_W-1:0] r_mem [QUEUE_DEPTH];
    logic [ENT_W-1:0] r_rd;

    logic [TAG_W-1:0] r_tag;
    logic [LEN_W-1:0] r_len;
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [TOT_W-1:0] r_tot, n_tot;
    logic [TOT_W-1:0] r_rel, n_rel;
    logic             r_strobe, n_strobe;
    t_kind            r_kind, n_kind;
    logic [TAG_W-1:0] r_otag, n_otag;
    logic [LEN_W-1:0] r_olen, n_olen;
    logic             r_last, n_last;

    logic [CMP_W-1:0] tot_x, rel_x, bud_x, thr_x;
    logic             full, admit, wr_en;
    logic [LEN_W-1:0] rd_len;
    logic [TAG_W-1:0] rd_tag;
    logic [CNT_W-1:0] pop_cnt;
    logic [TOT_W-1:0] pop_rel, pop_tot;
    logic             pop_more, pop_free;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign tot_x  = CMP_W'(r_tot);
    assign rel_x  = CMP_W'(r_rel);
    assign bud_x  = CMP_W'(i_budget);
    assign thr_x  = CMP_W'(i_threshold);
    assign full   = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign admit  = (tot_x < thr_x) && !full;
    assign wr_en  = i_cmd.sub && i_rate_enabled && admit;
    assign rd_len = r_rd[LEN_W-1:0];
    assign rd_tag = r_rd[ENT_W-1:LEN_W];

    assign pop_cnt  = r_cnt - CNT_W'(1);
    assign pop_rel  = r_rel + TOT_W'(rd_len);
    assign pop_tot  = r_tot - TOT_W'(rd_len);
    assign pop_more = (pop_cnt != '0) && (CMP_W'(pop_rel) < bud_x);
    assign pop_free = CMP_W'(pop_tot) < thr_x;

    assign o_sts.can_pop     = (r_cnt != '0) && (rel_x < bud_x);
    assign o_sts.bucket_free = tot_x < thr_x;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_tail] <= {r_tag, r_len};
        end
        r_rd <= r_mem[r_head];
    end

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_cnt    = r_cnt;
        n_tot    = r_tot;
        n_rel    = r_rel;
        n_strobe = 1'b0;
        n_kind   = r_kind;
        n_otag   = r_otag;
        n_olen   = r_olen;
        n_last   = r_last;
        if (i_cmd.ld) begin
            n_rel = '0;
        end
        if (i_cmd.sub) begin
            n_strobe = 1'b1;
            n_otag   = r_tag;
            n_olen   = r_len;
            n_last   = 1'b1;
            if (!i_rate_enabled) begin
                n_kind = KIND_DIRECT;
            end else if (admit) begin
                n_kind = KIND_QUEUED;
                n_tail = ptr_inc(r_tail);
                n_cnt  = r_cnt + CNT_W'(1);
                n_tot  = r_tot + TOT_W'(r_len);
            end else begin
                n_kind = KIND_REJECTED;
            end
        end
        if (i_cmd.pop) begin
            n_strobe = 1'b1;
            n_kind   = KIND_RELEASED;
            n_otag   = rd_tag;
            n_olen   = rd_len;
            n_last   = !(pop_more || pop_free);
            n_head   = ptr_inc(r_head);
            n_cnt    = pop_cnt;
            n_tot    = pop_tot;
            n_rel    = pop_rel;
        end
        if (i_cmd.free) begin
            n_strobe = 1'b1;
            n_kind   = KIND_FREED;
            n_otag   = '0;
            n_olen   = '0;
            n_last   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_cnt    <= '0;
            r_tot    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_cnt    <= n_cnt;
            r_tot    <= n_tot;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rel  <= n_rel;
        r_kind <= n_kind;
        r_otag <= n_otag;
        r_olen <= n_olen;
        r_last <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld) begin
            r_tag <= i_tag;
            r_len <= i_len;
        end
    end

    assign o_strobe = r_strobe;
    assign o_kind   = r_kind;
    assign o_tag    = r_otag;
    assign o_len    = r_olen;
    assign o_last   = r_last;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == '0 |-> r_head == r_tail)
        else $error("empty queue with head and tail apart");

    a_empty_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == '0 |-> r_tot == '0)
        else $error("empty queue with bytes outstanding");

    a_freed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && r_kind == KIND_FREED |-> r_otag == '0 && r_olen == '0 && r_last)
        else $error("bucket freed result carries payload");

endmodule

// ===== sv/prs_ctrl.sv =====
module prs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_opcode,
    input  prs_pkg::t_sts i_sts,
    output prs_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import prs_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.ld = 1'b1;
                    n_state  = i_opcode ? ST_TCHECK : ST_SUBMIT;
                end
            end
            ST_SUBMIT: begin
                o_cmd.sub = 1'b1;
                n_state   = ST_IDLE;
            end
            ST_TCHECK: begin
                if (i_sts.can_pop) begin
                    n_state = ST_TEMIT;
                end else begin
                    o_cmd.free = i_sts.bucket_free;
                    n_state    = ST_IDLE;
                end
            end
            ST_TEMIT: begin
                o_cmd.pop = 1'b1;
                n_state   = ST_TCHECK;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.ld, o_cmd.sub, o_cmd.pop, o_cmd.free}))
        else $error("more than one datapath command");

    a_emit_after_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_TEMIT |-> $past(r_state) == ST_TCHECK && $past(i_sts.can_pop))
        else $error("release without a passed check");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ld |=> o_busy)
        else $error("accepted transaction left controller idle");

endmodule

// ===== sv/packet_rate_shaper_unit.sv =====
// Channel   | Direction | Handshake          | Payload
// command   | in        | start, busy        | i_opcode, i_packet_tag, i_packet_length
// result    | out       | o_strobe (1 cycle) | o_result_kind, o_out_tag, o_out_length, o_last_result
// config    | in/out    | APB, pready high   | paddr, pwdata, prdata
//
// Submit: the result strobes on the cycle after the work cycle.
// Tick: a check, then a release and a new check for each descriptor released (one queue
// read port with registered read data); the final check issues bucket freed when due.
// Reset: synchronous, active low; clears queue pointers, count, byte total and config registers.
// The receiver cannot stall; results are taken on the cycle they strobe.
module packet_rate_shaper_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_opcode,
    input  logic [prs_pkg::TAG_W-1:0]     i_packet_tag,
    input  logic [prs_pkg::LEN_W-1:0]     i_packet_length,
    output logic                          o_strobe,
    output logic [prs_pkg::KIND_W-1:0]    o_result_kind,
    output logic [prs_pkg::TAG_W-1:0]     o_out_tag,
    output logic [prs_pkg::LEN_W-1:0]     o_out_length,
    output logic                          o_last_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [prs_pkg::PADDR_W-1:0]   paddr,
    input  logic [prs_pkg::PDATA_W-1:0]   pwdata,
    output logic [prs_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import prs_pkg::*;

    logic             r_rate_enabled;
    logic [CFG_W-1:0] r_budget;
    logic [CFG_W-1:0] r_threshold;
    logic [IDX_W-1:0] reg_idx;
    logic             cfg_wr;
    t_cmd             cmd;
    t_sts             sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_enabled <= 1'b0;
            r_budget       <= '0;
            r_threshold    <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_RATE_ENABLED:     r_rate_enabled <= pwdata[0];
                REG_TICK_BYTE_BUDGET: r_budget       <= pwdata[CFG_W-1:0];
                REG_BUCKET_THRESHOLD: r_threshold    <= pwdata[CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_RATE_ENABLED:     prdata = PDATA_W'(r_rate_enabled);
            REG_TICK_BYTE_BUDGET: prdata = PDATA_W'(r_budget);
            REG_BUCKET_THRESHOLD: prdata = PDATA_W'(r_threshold);
            default:              prdata = '0;
        endcase
    end

    prs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    prs_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_rate_enabled (r_rate_enabled),
        .i_budget       (r_budget),
        .i_threshold    (r_threshold),
        .i_tag          (i_packet_tag),
        .i_len          (i_packet_length),
        .o_strobe       (o_strobe),
        .o_kind         (o_result_kind),
        .o_tag          (o_out_tag),
        .o_len          (o_out_length),
        .o_last         (o_last_result)
    );

endmodule

// ===== dv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import prs_pkg::*;

    localparam int QUEUE_DEPTH    = 16;
    localparam int DRAIN_CYCLES   = 2 * QUEUE_DEPTH + 4;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic OP_SUBMIT = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [IDX_W-1:0] REG_UNLISTED = 2'd3;

    typedef struct packed {
        t_kind             kind;
        logic [TAG_W-1:0]  tag;
        logic [LEN_W-1:0]  len;
        logic              last;
    } t_outcome;

    typedef enum {
        ROW_WRITE,
        ROW_SUBMIT,
        ROW_TICK
    } t_row_kind;

    typedef struct {
        t_row_kind         kind;
        logic [IDX_W-1:0]  idx;
        logic [31:0]       data;
        logic [TAG_W-1:0]  tag;
        logic [LEN_W-1:0]  len;
        int                reps;
        t_kind             kind_due;
    } t_plan_row;

    logic                i_clk;
    logic                i_rst_n         = 1'b0;
    logic                start           = 1'b0;
    logic                busy;
    logic                i_opcode        = OP_SUBMIT;
    logic [TAG_W-1:0]    i_packet_tag    = '0;
    logic [LEN_W-1:0]    i_packet_length = '0;
    logic                o_strobe;
    logic [KIND_W-1:0]   o_result_kind;
    logic [TAG_W-1:0]    o_out_tag;
    logic [LEN_W-1:0]    o_out_length;
    logic                o_last_result;
    logic                psel            = 1'b0;
    logic                penable         = 1'b0;
    logic                pwrite          = 1'b0;
    logic [PADDR_W-1:0]  paddr           = '0;
    logic [PDATA_W-1:0]  pwdata          = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    logic [TAG_W-1:0]    bkt_tag [QUEUE_DEPTH];
    logic [LEN_W-1:0]    bkt_len [QUEUE_DEPTH];
    int                  bkt_head      = 0;
    int                  bkt_tail      = 0;
    int                  bkt_count     = 0;
    logic [31:0]         bkt_bytes     = '0;
    logic                cfg_rate_on   = 1'b0;
    logic [CFG_W-1:0]    cfg_budget    = '0;
    logic [CFG_W-1:0]    cfg_threshold = '0;

    t_outcome            outcomes_due[$];
    t_plan_row           plan[$];
    int                  mismatch_count = 0;
    int                  idle_cycles    = 0;
    int                  calm_left      = 0;

    packet_rate_shaper_unit #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_packet_tag   (i_packet_tag),
        .i_packet_length(i_packet_length),
        .o_strobe       (o_strobe),
        .o_result_kind  (o_result_kind),
        .o_out_tag      (o_out_tag),
        .o_out_length   (o_out_length),
        .o_last_result  (o_last_result),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic shape_transaction(input logic op, input logic [TAG_W-1:0] tag,
                                     input logic [LEN_W-1:0] len, input bit pinned,
                                     input t_kind pinned_kind);
        t_outcome         o;
        logic [31:0]      sent;
        logic [LEN_W-1:0] dlen;
        int               first;
        sent  = '0;
        first = outcomes_due.size();
        if (op == OP_SUBMIT) begin
            o.tag  = tag;
            o.len  = len;
            o.last = 1'b1;
            if (!cfg_rate_on) begin
                o.kind = KIND_DIRECT;
            end else if (bkt_bytes < 32'(cfg_threshold) && bkt_count < QUEUE_DEPTH) begin
                bkt_tag[bkt_tail] = tag;
                bkt_len[bkt_tail] = len;
                bkt_tail  = (bkt_tail + 1) % QUEUE_DEPTH;
                bkt_count = bkt_count + 1;
                bkt_bytes = bkt_bytes + 32'(len);
                o.kind    = KIND_QUEUED;
            end else begin
                o.kind = KIND_REJECTED;
            end
            if (pinned) begin
                o.kind = pinned_kind;
            end
            outcomes_due.push_back(o);
        end else begin
            while (bkt_count > 0 && sent < 32'(cfg_budget)) begin
                dlen      = bkt_len[bkt_head];
                o.kind    = KIND_RELEASED;
                o.tag     = bkt_tag[bkt_head];
                o.len     = dlen;
                o.last    = 1'b0;
                bkt_head  = (bkt_head + 1) % QUEUE_DEPTH;
                bkt_count = bkt_count - 1;
                sent      = sent + 32'(dlen);
                bkt_bytes = (bkt_bytes >= 32'(dlen)) ? bkt_bytes - 32'(dlen) : '0;
                outcomes_due.push_back(o);
            end
            if (bkt_bytes < 32'(cfg_threshold)) begin
                o.kind = KIND_FREED;
                o.tag  = '0;
                o.len  = '0;
                o.last = 1'b0;
                outcomes_due.push_back(o);
            end
            if (outcomes_due.size() > first) begin
                outcomes_due[$].last = 1'b1;
            end
        end
    endtask

    task automatic send(input logic op, input logic [TAG_W-1:0] tag,
                        input logic [LEN_W-1:0] len, input bit pinned,
                        input t_kind pinned_kind);
        start           <= 1'b1;
        i_opcode        <= op;
        i_packet_tag    <= tag;
        i_packet_length <= len;
        do @(posedge i_clk); while (busy !== 1'b0);
        shape_transaction(op, tag, len, pinned, pinned_kind);
    endtask

    task automatic pace();
        int gap;
        if (calm_left > 0) begin
            calm_left--;
            gap = 0;
        end else if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(5, 15);
            gap = 0;
        end else begin
            gap = $urandom_range(0, 12);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic await_outcomes();
        start <= 1'b0;
        while (outcomes_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic settle();
        await_outcomes();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [IDX_W-1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_RATE_ENABLED:     cfg_rate_on   = data[0];
            REG_TICK_BYTE_BUDGET: cfg_budget    = data[CFG_W-1:0];
            REG_BUCKET_THRESHOLD: cfg_threshold = data[CFG_W-1:0];
            default: ;
        endcase
    endtask

    function automatic t_plan_row row_write(input logic [IDX_W-1:0] idx,
                                            input logic [31:0] data);
        t_plan_row r;
        r = '{ROW_WRITE, idx, data, '0, '0, 0, KIND_QUEUED};
        return r;
    endfunction

    function automatic t_plan_row row_submit(input logic [TAG_W-1:0] tag,
                                             input logic [LEN_W-1:0] len, input int reps,
                                             input t_kind kind_due);
        t_plan_row r;
        r = '{ROW_SUBMIT, REG_RATE_ENABLED, '0, tag, len, reps, kind_due};
        return r;
    endfunction

    function automatic t_plan_row row_tick();
        t_plan_row r;
        r = '{ROW_TICK, REG_RATE_ENABLED, '0, '0, '0, 0, KIND_QUEUED};
        return r;
    endfunction

    function automatic logic [CFG_W-1:0] pick_level();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return CFG_W'($urandom_range(1, 1000));
            3:       return CFG_W'($urandom_range(1000, 200000));
            default: return CFG_W'($urandom);
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return LEN_W'($urandom_range(1, 400));
            4:       return LEN_W'($urandom_range(400, 65535));
            default: return LEN_W'($urandom);
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (outcomes_due.size() == 0) begin
                flag_mismatch("unexpected result kind", 32'(o_result_kind), '0);
            end else begin
                want = outcomes_due.pop_front();
                if (o_result_kind !== want.kind)
                    flag_mismatch("result_kind", 32'(o_result_kind), 32'(want.kind));
                if (o_out_tag !== want.tag)
                    flag_mismatch("out_tag", 32'(o_out_tag), 32'(want.tag));
                if (o_out_length !== want.len)
                    flag_mismatch("out_length", 32'(o_out_length), 32'(want.len));
                if (o_last_result !== want.last)
                    flag_mismatch("last_result", 32'(o_last_result), 32'(want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_strobe === 1'b1 || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        logic [31:0] rnd;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        plan.push_back(row_submit(16'hFFFF, 16'hFFFF, 1, KIND_DIRECT));
        plan.push_back(row_tick());
        plan.push_back(row_write(REG_UNLISTED, 32'hFFFF_FFFF));
        plan.push_back(row_write(REG_RATE_ENABLED, 32'h0000_0001));
        plan.push_back(row_submit(16'h1234, 16'h0064, 1, KIND_REJECTED));
        plan.push_back(row_write(REG_BUCKET_THRESHOLD, 32'h00FF_FFFF));
        plan.push_back(row_write(REG_TICK_BYTE_BUDGET, 32'hFF00_0000));
        plan.push_back(row_submit(16'h0000, 16'h0000, QUEUE_DEPTH, KIND_QUEUED));
        plan.push_back(row_submit(16'hBEEF, 16'h0001, 1, KIND_REJECTED));
        plan.push_back(row_tick());
        plan.push_back(row_write(REG_RATE_ENABLED, 32'hFFFF_FFFE));
        plan.push_back(row_write(REG_TICK_BYTE_BUDGET, 32'h00FF_FFFF));
        plan.push_back(row_tick());
        plan.push_back(row_submit(16'h0000, 16'h0000, 1, KIND_DIRECT));
        plan.push_back(row_write(REG_RATE_ENABLED, 32'h0000_0001));
        plan.push_back(row_write(REG_TICK_BYTE_BUDGET, 32'h0000_0001));
        plan.push_back(row_write(REG_BUCKET_THRESHOLD, 32'h0000_0001));
        plan.push_back(row_submit(16'hA5A5, 16'h0000, 1, KIND_QUEUED));
        plan.push_back(row_submit(16'h5A5A, 16'h0005, 1, KIND_QUEUED));
        plan.push_back(row_submit(16'hFFFF, 16'hFFFF, 1, KIND_REJECTED));
        plan.push_back(row_tick());
        plan.push_back(row_write(REG_BUCKET_THRESHOLD, 32'h0000_0000));
        plan.push_back(row_tick());

        foreach (plan[r]) begin
            case (plan[r].kind)
                ROW_WRITE: begin
                    settle();
                    apb_write(plan[r].idx, plan[r].data);
                end
                ROW_SUBMIT: begin
                    for (int k = 0; k < plan[r].reps; k++) begin
                        pace();
                        send(OP_SUBMIT, plan[r].tag + TAG_W'(k), plan[r].len + LEN_W'(k),
                             1'b1, plan[r].kind_due);
                    end
                end
                default: begin
                    pace();
                    send(OP_TICK, TAG_W'($urandom), LEN_W'($urandom), 1'b0, KIND_QUEUED);
                end
            endcase
        end

        for (int ph = 0; ph < 8; ph++) begin
            settle();
            rnd = $urandom;
            apb_write(REG_RATE_ENABLED, {rnd[31:1], !(ph == 2 || ph == 6)});
            rnd = $urandom;
            apb_write(REG_TICK_BYTE_BUDGET, {rnd[31:CFG_W], pick_level()});
            rnd = $urandom;
            apb_write(REG_BUCKET_THRESHOLD, {rnd[31:CFG_W], pick_level()});
            if (ph % 3 == 0) begin
                apb_write(REG_UNLISTED, $urandom);
            end
            for (int i = 0; i < 19; i++) begin
                if ((ph == 3 && i == 9) || $urandom_range(0, 39) == 0) begin
                    await_outcomes();
                end
                pace();
                if ($urandom_range(0, 4) == 0) begin
                    send(OP_TICK, TAG_W'($urandom), LEN_W'($urandom), 1'b0, KIND_QUEUED);
                end else begin
                    send(OP_SUBMIT, TAG_W'($urandom), pick_length(), 1'b0, KIND_QUEUED);
                end
            end
        end

        await_outcomes();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/prs_pkg.sv
sv/prs_dpath.sv
sv/prs_ctrl.sv
sv/packet_rate_shaper_unit.sv
dv/tb.sv
